// ----- rtl/hltp_pkg.sv -----
// ----------------------------------------------------------------------------
// hltp_pkg
// Shared types and constants for the linear-probing hash set.
// ----------------------------------------------------------------------------
package hltp_pkg;

    localparam int KEY_W    = 31;
    localparam int MULT_W   = 32;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = KEY_W + 1;

    localparam logic [MULT_W-1:0] MULT_RESET = 32'd2654435769;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_PRESENT   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ABSENT    = 3'd4;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_MUL,
        S_HOME,
        S_RD,
        S_CHK
    } state_t;

    typedef struct packed {
        logic                load;
        logic                mul;
        logic                home;
        logic                probe_next;
        logic                write_slot;
        logic                clr_write;
        logic                report;
        logic [STATUS_W-1:0] code;
    } cmd_t;

    typedef struct packed {
        logic slot_valid;
        logic slot_match;
        logic cnt_last;
        logic is_search;
    } sts_t;

endpackage

// ----- rtl/hltp_ram.sv -----
// ----------------------------------------------------------------------------
// hltp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hltp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/hltp_ctrl.sv -----
// ----------------------------------------------------------------------------
// hltp_ctrl
// Sequencer: table clear after reset, hash, then one probe per cycle.
// ----------------------------------------------------------------------------
module hltp_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  hltp_pkg::sts_t  sts,
    output hltp_pkg::cmd_t  cmd,
    output logic            busy
);

    import hltp_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLR:
            begin
                if (sts.cnt_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:  state_next = S_HOME;
            S_HOME: state_next = S_RD;
            S_RD:   state_next = S_CHK;
            S_CHK:
            begin
                if (!sts.slot_valid || sts.slot_match || sts.cnt_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_CLR;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            S_CLR:  cmd.clr_write = 1'b1;
            S_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            S_MUL:  cmd.mul  = 1'b1;
            S_HOME: cmd.home = 1'b1;
            S_RD:   ;
            S_CHK:
            begin
                if (!sts.slot_valid)
                begin
                    cmd.report = 1'b1;
                    if (sts.is_search)
                    begin
                        cmd.code = ST_ABSENT;
                    end
                    else
                    begin
                        cmd.code       = ST_INSERTED;
                        cmd.write_slot = 1'b1;
                    end
                end
                else if (sts.slot_match)
                begin
                    cmd.report = 1'b1;
                    cmd.code   = sts.is_search ? ST_PRESENT : ST_DUPLICATE;
                end
                else if (sts.cnt_last)
                begin
                    cmd.report = 1'b1;
                    cmd.code   = sts.is_search ? ST_ABSENT : ST_FULL;
                end
                else
                begin
                    cmd.probe_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

endmodule

// ----- rtl/hltp_dp.sv -----
// ----------------------------------------------------------------------------
// hltp_dp
// Datapath: multiplicative hash, probe pointer, slot RAM, result register.
// ----------------------------------------------------------------------------
module hltp_dp #(
    parameter int TABLE_SIZE = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          hash_multiplier_we,
    input  logic [hltp_pkg::MULT_W-1:0]   hash_multiplier,
    input  logic                          kind,
    input  logic [hltp_pkg::KEY_W-1:0]    key,
    input  hltp_pkg::cmd_t                cmd,
    output hltp_pkg::sts_t                sts,
    output logic                          done,
    output logic [hltp_pkg::STATUS_W-1:0] status
);

    import hltp_pkg::*;

    localparam int AW = $clog2(TABLE_SIZE);
    localparam int SW = $clog2(TABLE_SIZE + 1);
    localparam logic [AW-1:0] LAST = AW'(TABLE_SIZE - 1);

    logic [MULT_W-1:0]        mult_reg;
    logic                     kind_reg;
    logic [KEY_W-1:0]         key_reg;
    logic [MULT_W-1:0]        frac_reg;
    logic [AW-1:0]            pos_reg;
    logic [AW-1:0]            cnt_reg;
    logic                     done_reg;
    logic [STATUS_W-1:0]      status_reg;

    logic [KEY_W+MULT_W-1:0]  prod_full;
    logic [MULT_W+SW-1:0]     scaled;
    logic [AW-1:0]            pos_inc;
    logic [AW-1:0]            cnt_inc;
    logic [AW-1:0]            rd_addr;
    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic [SLOT_W-1:0]        ram_wdata;
    logic [SLOT_W-1:0]        ram_rdata;

    assign prod_full = key_reg * mult_reg;
    assign scaled    = frac_reg * SW'(TABLE_SIZE);
    assign pos_inc   = (pos_reg == LAST) ? '0 : pos_reg + 1'b1;
    assign cnt_inc   = (cnt_reg == LAST) ? '0 : cnt_reg + 1'b1;
    assign rd_addr   = cmd.probe_next ? pos_inc : pos_reg;

    assign ram_we    = cmd.clr_write | cmd.write_slot;
    assign ram_waddr = cmd.clr_write ? cnt_reg : pos_reg;
    assign ram_wdata = cmd.clr_write ? '0 : {1'b1, key_reg};

    hltp_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (TABLE_SIZE)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    assign sts.slot_valid = ram_rdata[SLOT_W-1];
    assign sts.slot_match = (ram_rdata[KEY_W-1:0] == key_reg);
    assign sts.cnt_last   = (cnt_reg == LAST);
    assign sts.is_search  = kind_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mult_reg <= MULT_RESET;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            if (hash_multiplier_we)
            begin
                mult_reg <= hash_multiplier;
            end
            if (cmd.home)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.clr_write || cmd.probe_next)
            begin
                cnt_reg <= cnt_inc;
            end
            done_reg <= cmd.report;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= kind;
            key_reg  <= key;
        end
        if (cmd.mul)
        begin
            frac_reg <= prod_full[MULT_W-1:0];
        end
        if (cmd.home)
        begin
            pos_reg <= scaled[MULT_W +: AW];
        end
        else if (cmd.probe_next)
        begin
            pos_reg <= pos_inc;
        end
        if (cmd.report)
        begin
            status_reg <= cmd.code;
        end
    end

    assign done   = done_reg;
    assign status = status_reg;

endmodule

// ----- rtl/hash_table_linear_probe_top.sv -----
// ----------------------------------------------------------------------------
// hash_table_linear_probe_top
// Open-addressing hash set with linear probing and a multiplicative hash.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: an item (kind, key) is taken on a rising edge with start
//   high and busy low. kind 0 inserts key, kind 1 searches for it.
//   Result channel: done pulses for one cycle with status; the receiver
//   cannot stall it, so it must take every result as it appears.
//   Config: hash_multiplier is written on an edge with hash_multiplier_we
//   high; write it only while the block is idle.
//   Sequence: once the item is taken, the hash is formed in the MUL and
//   HOME states and the RD state reads the home slot; CHK then checks n
//   slots (1 to TABLE_SIZE). The slot RAM gives one probe per cycle.
//   Flow: items are handled one at a time; busy drops in the cycle done
//   strobes, so the next item may be taken then.
//   Reset: the multiplier returns to its default and the slot RAM is swept
//   clear, one slot a cycle, over all TABLE_SIZE slots with busy held high.
// ----------------------------------------------------------------------------
module hash_table_linear_probe_top #(
    parameter int TABLE_SIZE = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          hash_multiplier_we,
    input  logic [hltp_pkg::MULT_W-1:0]   hash_multiplier,
    input  logic                          start,
    output logic                          busy,
    input  logic                          kind,
    input  logic [hltp_pkg::KEY_W-1:0]    key,
    output logic                          done,
    output logic [hltp_pkg::STATUS_W-1:0] status
);

    import hltp_pkg::*;

    cmd_t cmd;
    sts_t sts;

    hltp_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    hltp_dp #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .hash_multiplier_we (hash_multiplier_we),
        .hash_multiplier    (hash_multiplier),
        .kind               (kind),
        .key                (key),
        .cmd                (cmd),
        .sts                (sts),
        .done               (done),
        .status             (status)
    );

`ifndef NO_ASSERTIONS
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepting an item");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobed while busy");

    a_write_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_slot |-> !sts.slot_valid && !sts.is_search)
        else $error("insert wrote over a valid slot");

    a_probe_miss: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.probe_next |-> sts.slot_valid && !sts.slot_match && !sts.cnt_last)
        else $error("probe advanced past a hit, empty slot or full loop");

    a_report_once: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.report |=> !cmd.report)
        else $error("two results for one item");
`endif

endmodule
